>>> rtl/core/sirc_pkg.sv
// shared types and constants for the stereo impulse response convolver
// used by the mac lanes, the merge stage and the top level; no dependencies
package sirc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int ACC_W     = 48;
	localparam int TAP_CNT_W = 12;
	localparam int TAP_IDX_W = 11;

	// operation codes carried in tuser
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TAP    = 2'd1;
	localparam logic [1:0] OP_APPLY  = 2'd2;

	// configuration register indexes
	localparam logic REG_TAP_COUNT = 1'b0;
	localparam logic REG_STEREO    = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	// control that travels with each tap through the lane pipeline
	typedef struct packed {
		logic en;     // a tap is in flight
		logic first;  // first tap of the sample, restarts the sum
		logic last;   // last tap of the sample
		logic live;   // history slot holds a sample written since the last clear
	} lane_ctl_t;

endpackage

>>> rtl/core/stereo_impulse_response_convolver.sv
// top level of the stereo impulse response convolver: sequencer, rams, lanes
// depends on sirc_pkg, sirc_ram, sirc_mac_lane and sirc_merge
//
// a sample's taps pass the ram read, product and accumulator registers, with
//   one coefficient read and one multiply-accumulate per tap per cycle in each
//   channel lane; no new beat is taken until the sum is in the output register
// tap write, apply and unused opcodes are taken while idle and give no beat
// reset: after arst_n rises the coefficient ram is cleared, one entry a cycle,
//   with s_tready low; config writes are taken meanwhile
module stereo_impulse_response_convolver
	import sirc_pkg::*;
#(
	parameter int MAX_TAPS = 2048
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// left_sample[15:0], right_sample[31:16], tap_index[42:32], coef_value[58:43]
	input  logic [63:0]              s_tdata,
	// opcode[1:0]
	input  logic [1:0]               s_tuser,
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// out_left[15:0], out_right[31:16]
	output logic [2*SAMPLE_W-1:0]    m_tdata,
	// configuration writes
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [TAP_CNT_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_TAPS);
	localparam int CW = $clog2(MAX_TAPS + 1);

	// sequencer states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]           state_q;
	logic [TAP_CNT_W-1:0] tap_count_q;
	logic                 stereo_q;
	logic [AW-1:0]        clr_q;      // clearing pass address
	logic [AW-1:0]        head_q;     // slot the next sample goes to
	logic [AW-1:0]        rd_ptr_q;   // history slot of the current tap
	logic [CW-1:0]        fill_q;     // samples written since the last clear
	logic [CW-1:0]        k_q;        // current tap
	logic [CW-1:0]        last_q;     // last tap of this sample
	logic                 done_q;     // both lane sums final, waiting for the merge

	lane_ctl_t ctl_s0, ctl_s1, ctl_s2;

	// input beat fields
	sample_t              in_left, in_right, in_coef;
	logic [TAP_IDX_W-1:0] in_tap_idx;
	logic                 accept;
	logic                 is_sample, is_tap, is_apply;
	logic                 tap_ok;
	logic [31:0]          tc32;
	logic [CW-1:0]        taps_m1;
	logic                 merge_load;

	// ram ports
	logic                 coef_we;
	logic [AW-1:0]        coef_waddr;
	logic [SAMPLE_W-1:0]  coef_wdata;
	logic [SAMPLE_W-1:0]  coef_rdata, left_rdata, right_rdata;
	logic [SAMPLE_W-1:0]  right_wdata;
	acc_t                 acc_left, acc_right;

	assign in_left    = s_tdata[15:0];
	assign in_right   = s_tdata[31:16];
	assign in_tap_idx = s_tdata[42:32];
	assign in_coef    = s_tdata[58:43];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// opcode decode, the unused code does nothing
	always_comb begin
		is_sample = 1'b0;
		is_tap    = 1'b0;
		is_apply  = 1'b0;
		unique case (s_tuser)
			OP_SAMPLE: is_sample = 1'b1;
			OP_TAP:    is_tap    = 1'b1;
			OP_APPLY:  is_apply  = 1'b1;
			default: begin
			end
		endcase
	end

	// a tap write past the store is dropped
	assign tap_ok = (32'(in_tap_idx) < MAX_TAPS);

	// taps in use: zero means one, clamp to the store depth
	always_comb begin
		tc32 = 32'(tap_count_q);
		if (tc32 == 32'd0) begin
			taps_m1 = '0;
		end else if (tc32 > MAX_TAPS) begin
			taps_m1 = CW'(MAX_TAPS - 1);
		end else begin
			taps_m1 = CW'(tc32 - 32'd1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_CNT_W'(1);
			stereo_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAP_COUNT: tap_count_q <= cfg_data;
				REG_STEREO:    stereo_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			head_q   <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			k_q      <= '0;
			last_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_TAPS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && is_sample) begin
						// sample is written this edge, taps walk back from its slot
						rd_ptr_q <= head_q;
						head_q   <= (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + AW'(1);
						if (fill_q != CW'(MAX_TAPS)) begin
							fill_q <= fill_q + CW'(1);
						end
						k_q     <= '0;
						last_q  <= taps_m1;
						state_q <= ST_RUN;
					end else if (accept && is_apply) begin
						// histories read as zero again once the fill count is gone
						head_q <= '0;
						fill_q <= '0;
					end
				end
				ST_RUN: begin
					k_q      <= k_q + CW'(1);
					rd_ptr_q <= (rd_ptr_q == '0) ? AW'(MAX_TAPS - 1) : rd_ptr_q - AW'(1);
					if (k_q == last_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (merge_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tap issue control and its pipeline
	always_comb begin
		ctl_s0.en    = (state_q == ST_RUN);
		ctl_s0.first = (k_q == '0);
		ctl_s0.last  = (k_q == last_q);
		ctl_s0.live  = (k_q < fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
			if (ctl_s2.en && ctl_s2.last) begin
				done_q <= 1'b1;
			end else if (merge_load) begin
				done_q <= 1'b0;
			end
		end
	end

	// result moves to the output register once that is free
	assign merge_load = (state_q == ST_WAIT) && done_q && (!m_tvalid || m_tready);

	// coefficient store: clearing pass after reset, then tap writes
	assign coef_we    = (state_q == ST_CLEAR) || (accept && is_tap && tap_ok);
	assign coef_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(in_tap_idx);
	assign coef_wdata = (state_q == ST_CLEAR) ? '0 : in_coef;

	// mono stores zero in the right history
	assign right_wdata = stereo_q ? in_right : '0;

	sirc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (k_q[AW-1:0]),
		.rdata (coef_rdata)
	);

	sirc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_left_ram (
		.clk   (clk),
		.we    (accept && is_sample),
		.waddr (head_q),
		.wdata (in_left),
		.raddr (rd_ptr_q),
		.rdata (left_rdata)
	);

	sirc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_right_ram (
		.clk   (clk),
		.we    (accept && is_sample),
		.waddr (head_q),
		.wdata (right_wdata),
		.raddr (rd_ptr_q),
		.rdata (right_rdata)
	);

	// one lane per channel, sharing the coefficient read
	sirc_mac_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.ctl_s2 (ctl_s2),
		.coef   (coef_rdata),
		.sample (left_rdata),
		.acc    (acc_left)
	);

	sirc_mac_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.ctl_s2 (ctl_s2),
		.coef   (coef_rdata),
		.sample (right_rdata),
		.acc    (acc_right)
	);

	sirc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (merge_load),
		.stereo    (stereo_q),
		.acc_left  (acc_left),
		.acc_right (acc_right),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// finished sums only wait while the sequencer waits for them
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_WAIT))
		else $error("lane sums finished outside the wait state");

	// fill count never passes the history depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_TAPS)
		else $error("history fill count past depth");

	// an accepted sample beat always starts the tap walk
	a_sample_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_sample) |=> (state_q == ST_RUN) && (k_q == '0))
		else $error("sample beat did not start the tap walk");

	// no tap issue while the coefficient store is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready && !ctl_s1.en && !ctl_s2.en)
		else $error("activity during the clearing pass");

endmodule

>>> rtl/core/sirc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sirc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/sirc_mac_lane.sv
// one multiply-accumulate lane: product register then 48-bit accumulator
// depends on sirc_pkg
module sirc_mac_lane
	import sirc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lane_ctl_t ctl_s1,   // aligned with the ram read data
	input  lane_ctl_t ctl_s2,   // aligned with the product register
	input  sample_t   coef,
	input  sample_t   sample,
	output acc_t      acc
);

	logic signed [2*SAMPLE_W-1:0] prod;
	logic signed [2*SAMPLE_W-1:0] prod_s2;
	acc_t                         acc_q;

	// signed q1.15 by q1.15 product, q2.30
	assign prod = coef * sample;

	// slots not written since the last clear read as zero
	always_ff @(posedge clk) begin
		if (ctl_s1.en) begin
			prod_s2 <= ctl_s1.live ? prod : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl_s2.en) begin
			acc_q <= ctl_s2.first ? acc_t'(prod_s2) : acc_q + acc_t'(prod_s2);
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/sirc_merge.sv
// merge stage: rounds and saturates both lane sums and holds the result beat
// depends on sirc_pkg
module sirc_merge
	import sirc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    stereo,
	input  acc_t                    acc_left,
	input  acc_t                    acc_right,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [2*SAMPLE_W-1:0]   m_tdata
);

	localparam int Q_W = ACC_W + 1 - 15;

	// round half up, then clamp to q1.15
	function automatic sample_t round_sat(input acc_t a);
		logic signed [ACC_W:0] biased;
		logic signed [Q_W-1:0] q;
		sample_t               r;
		biased = (ACC_W + 1)'(a) + (ACC_W + 1)'(16384);
		q = $signed(biased[ACC_W:15]);
		if (q > $signed(Q_W'(32767))) begin
			r = 16'sh7fff;
		end else if (q < -$signed(Q_W'(32768))) begin
			r = 16'sh8000;
		end else begin
			r = q[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	logic                  valid_q;
	logic [2*SAMPLE_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {stereo ? round_sat(acc_right) : sample_t'(0), round_sat(acc_left)};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

>>> sim/tb.sv
// testbench for stereo_impulse_response_convolver: a directed table, then random phases
// each result beat is checked against a behavioral fir predictor or a typed expectation
// depends on sirc_pkg and the convolver rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sirc_pkg::*;

	localparam int         DEPTH      = 2048;
	localparam int         CYCLE_CAP  = 600_000;
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         DIR_N      = 15;
	localparam int         PHASE_N    = 9;

	// one input beat, with an optional hand-written expectation
	typedef struct packed {
		logic [1:0]           op;
		sample_t              left;
		sample_t              right;
		logic [TAP_IDX_W-1:0] idx;
		sample_t              coef;
		logic                 has_want;
		sample_t              want_l;
		sample_t              want_r;
	} stim_row_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
	} out_pair_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata   = '0;
	logic [1:0]           s_tuser   = OP_SAMPLE;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [2*SAMPLE_W-1:0] m_tdata;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = REG_TAP_COUNT;
	logic [TAP_CNT_W-1:0] cfg_data  = '0;

	stereo_impulse_response_convolver #(.MAX_TAPS(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	sample_t              coef_mem   [DEPTH];
	sample_t              hist_left  [DEPTH];
	sample_t              hist_right [DEPTH];
	logic [TAP_IDX_W-1:0] hist_head;
	logic [TAP_CNT_W-1:0] tap_cnt;
	bit                   stereo_on;

	out_pair_t   pending_out[$];
	int unsigned mismatches = 0;
	int unsigned cycles     = 0;
	bit          idle_ok    = 1'b1;
	int unsigned rx_hold    = 0;

	// directed table; taps stay at 1 here, so typed results depend on coef 0 only
	stim_row_t dir_rows [DIR_N] = '{
		// zero coefficients after reset
		'{OP_SAMPLE, 16'h7fff, 16'h8000, 11'd0,    16'h0000, 1'b1, 16'h0000, 16'h0000},
		'{OP_TAP,    16'h0000, 16'h0000, 11'd0,    16'h7fff, 1'b0, 16'h0000, 16'h0000},
		'{OP_SAMPLE, 16'h7fff, 16'h8000, 11'd0,    16'h0000, 1'b1, 16'h7ffe, 16'h8001},
		'{OP_TAP,    16'h0000, 16'h0000, 11'd0,    16'h8000, 1'b0, 16'h0000, 16'h0000},
		// -1 * -1 saturates
		'{OP_SAMPLE, 16'h8000, 16'h8000, 11'd0,    16'h0000, 1'b1, 16'h7fff, 16'h7fff},
		'{OP_SAMPLE, 16'h7fff, 16'h0000, 11'd0,    16'h0000, 1'b1, 16'h8001, 16'h0000},
		// unit lsb coefficient shows the half-up rounding
		'{OP_TAP,    16'h0000, 16'h0000, 11'd0,    16'h0001, 1'b0, 16'h0000, 16'h0000},
		'{OP_SAMPLE, 16'h4000, 16'hc000, 11'd0,    16'h0000, 1'b1, 16'h0001, 16'h0000},
		'{OP_SAMPLE, 16'h3fff, 16'hbfff, 11'd0,    16'h0000, 1'b1, 16'h0000, 16'hffff},
		'{OP_TAP,    16'h0000, 16'h0000, 11'd2047, 16'h5555, 1'b0, 16'h0000, 16'h0000},
		'{OP_TAP,    16'h0000, 16'h0000, 11'd1,    16'haaaa, 1'b0, 16'h0000, 16'h0000},
		'{OP_UNUSED, 16'hffff, 16'hffff, 11'd2047, 16'hffff, 1'b0, 16'h0000, 16'h0000},
		'{OP_SAMPLE, 16'h1234, 16'hfedc, 11'd0,    16'h0000, 1'b0, 16'h0000, 16'h0000},
		'{OP_APPLY,  16'h0000, 16'h0000, 11'd0,    16'h0000, 1'b0, 16'h0000, 16'h0000},
		'{OP_SAMPLE, 16'h8000, 16'h7fff, 11'd0,    16'h0000, 1'b0, 16'h0000, 16'h0000}
	};

	// phase settings: -1 taps and 2 stereo mean pick at random
	int phase_taps   [PHASE_N] = '{0, 7, 2048, 4095, -1, -1, -1, -1, 3};
	int phase_stereo [PHASE_N] = '{1, 0, 1, 0, 2, 2, 2, 2, 1};
	int phase_len    [PHASE_N] = '{30, 40, 10, 8, 40, 40, 40, 40, 30};

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int active_taps();
		if (tap_cnt == 0)
			return 1;
		if (tap_cnt > DEPTH)
			return DEPTH;
		return tap_cnt;
	endfunction

	function automatic void clear_history();
		foreach (hist_left[i]) begin
			hist_left[i]  = '0;
			hist_right[i] = '0;
		end
		hist_head = '0;
	endfunction

	// direct-form sum walking back from the newest sample, rounded and clamped
	function automatic sample_t fir_sum(input bit right_ch);
		logic [TAP_IDX_W-1:0] pos;
		longint               acc;
		longint               q;
		pos = hist_head;
		acc = 0;
		for (int k = 0; k < active_taps(); k++) begin
			acc += longint'(coef_mem[k]) *
				longint'(right_ch ? hist_right[pos] : hist_left[pos]);
			pos = pos - 1'b1;
		end
		q = (acc + 16384) >>> 15;
		if (q > 32767)
			return 16'h7fff;
		if (q < -32768)
			return 16'h8000;
		return sample_t'(q);
	endfunction

	function automatic bit step_model(input stim_row_t r, output out_pair_t y);
		y = '0;
		case (r.op)
			OP_TAP: begin
				coef_mem[r.idx] = r.coef;
				return 1'b0;
			end
			OP_APPLY: begin
				clear_history();
				return 1'b0;
			end
			OP_SAMPLE: begin
				hist_left[hist_head]  = r.left;
				hist_right[hist_head] = stereo_on ? r.right : sample_t'(0);
				y.left  = fir_sum(1'b0);
				y.right = stereo_on ? fir_sum(1'b1) : sample_t'(0);
				hist_head = hist_head + 1'b1;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// extremes, small values near zero, or anything
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 5))
			0: case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h0000;
				default: return 16'hffff;
			endcase
			1: return sample_t'($signed($urandom_range(0, 128)) - 64);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t   r;
		int unsigned pick;
		r = '0;
		pick = $urandom_range(0, 99);
		if (pick < 68)
			r.op = OP_SAMPLE;
		else if (pick < 88)
			r.op = OP_TAP;
		else if (pick < 94)
			r.op = OP_APPLY;
		else
			r.op = OP_UNUSED;
		r.left  = pick_sample();
		r.right = pick_sample();
		r.coef  = pick_sample();
		// at least half the tap writes land inside the taps in use
		if ($urandom_range(0, 1))
			r.idx = TAP_IDX_W'($urandom_range(0, active_taps() - 1));
		else
			r.idx = TAP_IDX_W'($urandom_range(0, DEPTH - 1));
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(input stim_row_t r);
		out_pair_t want;
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = r.op;
		s_tdata  = {5'b0, r.coef, r.idx, r.right, r.left};
		do
			@(posedge clk);
		while (!s_tready);
		if (step_model(r, want)) begin
			if (r.has_want)
				want = '{r.want_l, r.want_r};
			pending_out.push_back(want);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [TAP_CNT_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		if (idx == REG_TAP_COUNT)
			tap_cnt = val;
		else
			stereo_on = val[0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_out.size() != 0)
			@(negedge clk);
	endtask

	// receiver: ready stretches and stall bursts, always ready in the last phase
	always @(negedge clk) begin
		if (!idle_ok) begin
			m_tready <= 1'b1;
		end else if (rx_hold > 1) begin
			rx_hold <= rx_hold - 1;
		end else if (m_tready && $urandom_range(0, 2) == 0) begin
			m_tready <= 1'b0;
			rx_hold  <= $urandom_range(1, 11);
		end else begin
			m_tready <= 1'b1;
			rx_hold  <= $urandom_range(1, 30);
		end
	end

	// result checker
	always @(posedge clk) begin
		out_pair_t want;
		sample_t   got_l;
		sample_t   got_r;
		if (arst_n && m_tvalid && m_tready) begin
			got_l = m_tdata[15:0];
			got_r = m_tdata[31:16];
			if (pending_out.size() == 0) begin
				report_mismatch($sformatf("result beat %0d/%0d with nothing expected",
					got_l, got_r));
			end else begin
				want = pending_out.pop_front();
				if (got_l !== want.left)
					report_mismatch($sformatf("out_left got %0d want %0d",
						got_l, want.left));
				if (got_r !== want.right)
					report_mismatch($sformatf("out_right got %0d want %0d",
						got_r, want.right));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_CAP) begin
			$display("timeout with %0d results outstanding", pending_out.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int taps_val;
		int st_val;
		foreach (coef_mem[i])
			coef_mem[i] = '0;
		clear_history();
		tap_cnt   = 12'd1;
		stereo_on = 1'b1;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed part at reset settings; the block clears its coef ram first
		foreach (dir_rows[i])
			send_beat(dir_rows[i]);

		for (int p = 0; p < PHASE_N; p++) begin
			// settings change only with the block idle
			wait_drained();
			repeat (active_taps() + 10) @(negedge clk);
			taps_val = phase_taps[p] < 0 ? $urandom_range(1, 40) : phase_taps[p];
			st_val   = phase_stereo[p] > 1 ? $urandom_range(0, 1) : phase_stereo[p];
			write_reg(REG_TAP_COUNT, TAP_CNT_W'(taps_val));
			write_reg(REG_STEREO, TAP_CNT_W'(st_val));
			idle_ok = (p != PHASE_N - 1);
			for (int n = 0; n < phase_len[p]; n++)
				send_beat(random_row());
		end

		wait_drained();
		repeat (active_taps() + 20) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
